>>> src/tci_pkg.sv
// Shared constants and codes for the toroidal convolution unit.
`default_nettype none

package tci_pkg;

   // Parameter defaults
   localparam int DEF_MAX_ROWS   = 64;
   localparam int DEF_MAX_COLS   = 64;
   localparam int DEF_MAX_KERNEL = 9;

   // Data word width
   localparam int DATA_W = 32;

   // Request modes
   localparam logic [1:0] MODE_LOAD_COEF  = 2'd0;
   localparam logic [1:0] MODE_LOAD_PIXEL = 2'd1;
   localparam logic [1:0] MODE_RUN        = 2'd2;
   localparam logic [1:0] MODE_READ       = 2'd3;

   // Response kinds
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_RUN  = 1'b1;

   // Register indexes
   localparam logic [1:0] CSR_ROWS        = 2'd0;
   localparam logic [1:0] CSR_COLS        = 2'd1;
   localparam logic [1:0] CSR_KERNEL_SIZE = 2'd2;
   localparam logic [1:0] CSR_ITERATIONS  = 2'd3;

   // Register reset values
   localparam logic [6:0]  RST_ROWS        = 7'd64;
   localparam logic [6:0]  RST_COLS        = 7'd64;
   localparam logic [3:0]  RST_KERNEL_SIZE = 4'd3;
   localparam logic [15:0] RST_ITERATIONS  = 16'd1;

endpackage : tci_pkg

`default_nettype wire

>>> src/toroidal_conv2d_iterate_unit.sv
// Top level: toroidal 2-D convolution engine with iterated passes.
//
//  Channel | Ports                                  | Handshake
//  --------+----------------------------------------+------------------------------
//  request | start, busy, req_mode/row/col/value    | taken when start & !busy
//  result  | rsp_valid, rsp_pixel, rsp_kind         | one-cycle strobe, no stall
//  config  | csr_we, csr_index, csr_data            | written when csr_we is high
//
// A load takes its accept cycle; a read answers in the cycle after it is taken.
// A run holds busy high through set-up, which steps the first window's corner back by
// p = (kernel_size-1)/2, then per pass takes each pixel through w*w taps (w = 2p + 1) on
// one shared multiply-accumulate, pipeline drain and a 32-step divider, then a copy
// sweep, then the completion state; all sizes after saturation. Zero iterations: the
// completion state only. Reset clears control only; the stores hold garbage until
// written. The receiver cannot stall results.
`default_nettype none

module toroidal_conv2d_iterate_unit
   import tci_pkg::*;
#(
   parameter int MAX_ROWS   = DEF_MAX_ROWS,
   parameter int MAX_COLS   = DEF_MAX_COLS,
   parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_mode,
   input  wire logic [5:0]         req_row,
   input  wire logic [5:0]         req_col,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_pixel,
   output logic                    rsp_kind,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_data
);
   localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int KW   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int NRW  = $clog2(MAX_ROWS + 1);
   localparam int NCW  = $clog2(MAX_COLS + 1);
   localparam int KDW  = $clog2(MAX_KERNEL + 1);
   localparam int DDW  = 2 * KDW;
   localparam int IAW  = RW + CW;
   localparam int KAW  = 2 * KW;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PREP  = 3'd1;
   localparam logic [2:0] S_MAC   = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_COPY  = 3'd4;
   localparam logic [2:0] S_NEXT  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   // Configuration registers
   logic [6:0]  rows_ff;
   logic [6:0]  cols_ff;
   logic [3:0]  ksize_ff;
   logic [15:0] iters_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= RST_ROWS;
         cols_ff  <= RST_COLS;
         ksize_ff <= RST_KERNEL_SIZE;
         iters_ff <= RST_ITERATIONS;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ROWS:        rows_ff  <= csr_data[6:0];
            CSR_COLS:        cols_ff  <= csr_data[6:0];
            CSR_KERNEL_SIZE: ksize_ff <= csr_data[3:0];
            CSR_ITERATIONS:  iters_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Sequencer state
   logic [2:0]     state_ff, state_in;
   logic [NRW-1:0] nr_ff, nr_in;
   logic [NCW-1:0] nc_ff, nc_in;
   logic [KDW-1:0] twop_ff, twop_in;
   logic [KDW-1:0] p_ff, p_in;
   logic [DDW-1:0] dd_ff, dd_in;
   logic [15:0]    pass_ff, pass_in;
   logic [KDW-1:0] prep_ff, prep_in;
   logic [RW-1:0]  rs0_ff, rs0_in, rs_ff, rs_in, ri_ff, ri_in, i_ff, i_in;
   logic [CW-1:0]  cs0_ff, cs0_in, cs_ff, cs_in, cj_ff, cj_in, j_ff, j_in;
   logic [KW-1:0]  x_ff, x_in, y_ff, y_in;

   // Datapath pipeline
   logic              s1_vld_ff, s1_first_ff, s1_last_ff;
   logic              s2_vld_ff, s2_first_ff, s2_last_ff;
   logic [DATA_W-1:0] prod_ff, acc_ff;
   logic              acc_done_ff;
   logic              cp_vld_ff;
   logic [IAW-1:0]    cp_addr_ff;
   logic              rd_vld_ff, rd_oob_ff;

   logic              accept;
   logic              mac_issue, cp_issue;
   logic              div_done;
   logic [DATA_W-1:0] quot;
   logic [DATA_W-1:0] img_rdata, scr_rdata, ker_rdata;
   logic              img_we;
   logic [IAW-1:0]    img_waddr, img_raddr;
   logic [DATA_W-1:0] img_wdata;
   logic              ker_we, scr_we;
   logic              pix_in_range, coef_in_range;
   logic [KDW-1:0]    d_sel;
   logic [NRW-1:0]    nr_sel;
   logic [NCW-1:0]    nc_sel;
   logic              last_x, last_y, last_i, last_j;

   function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] v, input logic [NRW-1:0] n);
      return (v == RW'(n - 1'b1)) ? '0 : v + 1'b1;
   endfunction

   function automatic logic [RW-1:0] row_dec(input logic [RW-1:0] v, input logic [NRW-1:0] n);
      return (v == '0) ? RW'(n - 1'b1) : v - 1'b1;
   endfunction

   function automatic logic [CW-1:0] col_inc(input logic [CW-1:0] v, input logic [NCW-1:0] n);
      return (v == CW'(n - 1'b1)) ? '0 : v + 1'b1;
   endfunction

   function automatic logic [CW-1:0] col_dec(input logic [CW-1:0] v, input logic [NCW-1:0] n);
      return (v == '0) ? CW'(n - 1'b1) : v - 1'b1;
   endfunction

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   assign pix_in_range  = (32'(req_row) < MAX_ROWS) && (32'(req_col) < MAX_COLS);
   assign coef_in_range = (32'(req_row) < MAX_KERNEL) && (32'(req_col) < MAX_KERNEL);

   // Saturate the geometry registers into the supported range
   always_comb begin
      if (rows_ff == '0)                 nr_sel = NRW'(1);
      else if (32'(rows_ff) > MAX_ROWS)  nr_sel = NRW'(MAX_ROWS);
      else                               nr_sel = NRW'(rows_ff);
      if (cols_ff == '0)                 nc_sel = NCW'(1);
      else if (32'(cols_ff) > MAX_COLS)  nc_sel = NCW'(MAX_COLS);
      else                               nc_sel = NCW'(cols_ff);
      if (ksize_ff == '0)                d_sel = KDW'(1);
      else if (32'(ksize_ff) > MAX_KERNEL) d_sel = KDW'(MAX_KERNEL);
      else                               d_sel = KDW'(ksize_ff);
   end

   assign last_x = (KDW'(x_ff) == twop_ff);
   assign last_y = (KDW'(y_ff) == twop_ff);
   assign last_i = (i_ff == RW'(nr_ff - 1'b1));
   assign last_j = (j_ff == CW'(nc_ff - 1'b1));

   // Sequencer: walk windows, pixels, the copy sweep and passes
   always_comb begin
      state_in = state_ff;
      nr_in    = nr_ff;
      nc_in    = nc_ff;
      twop_in  = twop_ff;
      p_in     = p_ff;
      dd_in    = dd_ff;
      pass_in  = pass_ff;
      prep_in  = prep_ff;
      rs0_in   = rs0_ff;
      cs0_in   = cs0_ff;
      rs_in    = rs_ff;
      cs_in    = cs_ff;
      ri_in    = ri_ff;
      cj_in    = cj_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      mac_issue = 1'b0;
      cp_issue  = 1'b0;
      scr_we    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_mode == MODE_RUN)) begin
               nr_in   = nr_sel;
               nc_in   = nc_sel;
               p_in    = (d_sel - 1'b1) >> 1;
               twop_in = ((d_sel - 1'b1) >> 1) << 1;
               dd_in   = DDW'(d_sel) * DDW'(d_sel);
               pass_in = '0;
               prep_in = '0;
               rs0_in  = '0;
               cs0_in  = '0;
               state_in = (iters_ff == '0) ? S_DONE : S_PREP;
            end
         end
         S_PREP: begin
            // Step the first window's corner back by the half width, wrapping
            if (prep_ff == p_ff) begin
               i_in  = '0;
               j_in  = '0;
               rs_in = rs0_ff;
               cs_in = cs0_ff;
               ri_in = rs0_ff;
               cj_in = cs0_ff;
               x_in  = '0;
               y_in  = '0;
               state_in = S_MAC;
            end else begin
               rs0_in  = row_dec(rs0_ff, nr_ff);
               cs0_in  = col_dec(cs0_ff, nc_ff);
               prep_in = prep_ff + 1'b1;
            end
         end
         S_MAC: begin
            mac_issue = 1'b1;
            if (last_y) begin
               y_in  = '0;
               cj_in = cs_ff;
               if (last_x) begin
                  state_in = S_DRAIN;
               end else begin
                  x_in  = x_ff + 1'b1;
                  ri_in = row_inc(ri_ff, nr_ff);
               end
            end else begin
               y_in  = y_ff + 1'b1;
               cj_in = col_inc(cj_ff, nc_ff);
            end
         end
         S_DRAIN: begin
            if (div_done) begin
               scr_we = 1'b1;
               x_in = '0;
               y_in = '0;
               state_in = S_MAC;
               if (last_j) begin
                  j_in  = '0;
                  cs_in = cs0_ff;
                  cj_in = cs0_ff;
                  if (last_i) begin
                     i_in = '0;
                     state_in = S_COPY;
                  end else begin
                     i_in  = i_ff + 1'b1;
                     rs_in = row_inc(rs_ff, nr_ff);
                     ri_in = row_inc(rs_ff, nr_ff);
                  end
               end else begin
                  j_in  = j_ff + 1'b1;
                  cs_in = col_inc(cs_ff, nc_ff);
                  cj_in = col_inc(cs_ff, nc_ff);
                  ri_in = rs_ff;
               end
            end
         end
         S_COPY: begin
            cp_issue = 1'b1;
            if (last_j) begin
               j_in = '0;
               if (last_i) begin
                  i_in = '0;
                  state_in = S_NEXT;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_NEXT: begin
            // Last copy write lands this cycle; count the pass
            pass_in = pass_ff + 1'b1;
            if ((pass_ff + 1'b1) == iters_ff) begin
               state_in = S_DONE;
            end else begin
               i_in  = '0;
               j_in  = '0;
               rs_in = rs0_ff;
               cs_in = cs0_ff;
               ri_in = rs0_ff;
               cj_in = cs0_ff;
               x_in  = '0;
               y_in  = '0;
               state_in = S_MAC;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         pass_ff     <= '0;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         acc_done_ff <= 1'b0;
         cp_vld_ff   <= 1'b0;
         rd_vld_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pass_ff     <= pass_in;
         s1_vld_ff   <= mac_issue;
         s2_vld_ff   <= s1_vld_ff;
         acc_done_ff <= s2_vld_ff && s2_last_ff;
         cp_vld_ff   <= cp_issue;
         rd_vld_ff   <= accept && (req_mode == MODE_READ);
      end
      nr_ff   <= nr_in;
      nc_ff   <= nc_in;
      twop_ff <= twop_in;
      p_ff    <= p_in;
      dd_ff   <= dd_in;
      prep_ff <= prep_in;
      rs0_ff  <= rs0_in;
      cs0_ff  <= cs0_in;
      rs_ff   <= rs_in;
      cs_ff   <= cs_in;
      ri_ff   <= ri_in;
      cj_ff   <= cj_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      // Window element tags travel with the RAM read data
      s1_first_ff <= (x_ff == '0) && (y_ff == '0);
      s1_last_ff  <= last_x && last_y;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      // Multiply, then accumulate modulo 2^32
      prod_ff <= ker_rdata * img_rdata;
      if (s2_vld_ff) begin
         acc_ff <= (s2_first_ff ? '0 : acc_ff) + prod_ff;
      end
      cp_addr_ff <= {i_ff, j_ff};
      rd_oob_ff  <= !pix_in_range;
   end

   // Image store port selection: host transactions while idle, engine otherwise
   assign img_we    = (accept && (req_mode == MODE_LOAD_PIXEL) && pix_in_range) || cp_vld_ff;
   assign img_waddr = cp_vld_ff ? cp_addr_ff : {RW'(req_row), CW'(req_col)};
   assign img_wdata = cp_vld_ff ? scr_rdata : req_value;
   assign img_raddr = busy ? {ri_ff, cj_ff} : {RW'(req_row), CW'(req_col)};
   assign ker_we    = accept && (req_mode == MODE_LOAD_COEF) && coef_in_range;

   tci_ram #(.WIDTH(DATA_W), .DEPTH(1 << IAW)) u_image (
      .clock (clock),
      .we    (img_we),
      .waddr (img_waddr),
      .wdata (img_wdata),
      .raddr (img_raddr),
      .rdata (img_rdata)
   );

   tci_ram #(.WIDTH(DATA_W), .DEPTH(1 << IAW)) u_scratch (
      .clock (clock),
      .we    (scr_we),
      .waddr ({i_ff, j_ff}),
      .wdata (quot),
      .raddr ({i_ff, j_ff}),
      .rdata (scr_rdata)
   );

   tci_ram #(.WIDTH(DATA_W), .DEPTH(1 << KAW)) u_kernel (
      .clock (clock),
      .we    (ker_we),
      .waddr ({KW'(req_row), KW'(req_col)}),
      .wdata (req_value),
      .raddr ({x_ff, y_ff}),
      .rdata (ker_rdata)
   );

   tci_div #(.DW(DDW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (acc_done_ff),
      .dividend (acc_ff),
      .divisor  (dd_ff),
      .done     (div_done),
      .quotient (quot)
   );

   // Result strobe: read data in the cycle after the request is taken, or run completion
   assign rsp_valid = rd_vld_ff || (state_ff == S_DONE);
   assign rsp_kind  = (state_ff == S_DONE) ? KIND_RUN : KIND_READ;
   assign rsp_pixel = ((state_ff == S_DONE) || rd_oob_ff) ? '0 : img_rdata;

endmodule : toroidal_conv2d_iterate_unit

`default_nettype wire

>>> src/tci_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tci_ram
   import tci_pkg::*;
#(
   parameter int WIDTH = DATA_W,
   parameter int DEPTH = 16
) (
   input  wire logic                                          clock,
   input  wire logic                                          we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                              wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                              rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule : tci_ram

`default_nettype wire

>>> src/tci_div.sv
// Bit-serial divider of a signed dividend by an unsigned divisor, truncating toward zero, one quotient bit per cycle.
`default_nettype none

module tci_div
   import tci_pkg::*;
#(
   parameter int DW = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DATA_W-1:0] dividend,
   input  wire logic [DW-1:0]     divisor,
   output logic                   done,
   output logic [DATA_W-1:0]      quotient
);
   localparam int CW = $clog2(DATA_W + 1);

   logic [DATA_W-1:0] mag_ff, mag_in;
   logic [DW:0]       rem_ff, rem_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              neg_ff, neg_in;
   logic              done_ff, done_in;
   logic [DW:0]       rem_sh;
   logic [DW:0]       dvs;

   assign dvs    = {1'b0, divisor};
   assign rem_sh = {rem_ff[DW-1:0], mag_ff[DATA_W-1]};

   // One restoring step per cycle; quotient bits shift into the magnitude word
   always_comb begin
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (start) begin
         neg_in = dividend[DATA_W-1];
         mag_in = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (rem_sh >= dvs) begin
            rem_in = rem_sh - dvs;
            mag_in = {mag_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            mag_in = {mag_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DATA_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~mag_ff + 1'b1) : mag_ff;

endmodule : tci_div

`default_nettype wire
